// ===== hdl/cgtc_pkg.sv =====
package cgtc_pkg;

    // pipeline depth, input register through output register
    localparam int NUM_STAGES = 8;

    // direction codes
    localparam logic KIND_CAL2GPS = 1'b0;
    localparam logic KIND_GPS2CAL = 1'b1;

    // calendar span
    localparam int YEAR_MIN = 1980;
    localparam int YEAR_MAX = 2200;

    // time units in milliseconds
    localparam int MS_PER_MIN  = 60000;
    localparam int MS_PER_HOUR = 3600000;
    localparam int MS_PER_DAY  = 86400000;
    localparam int MS_PER_WEEK = 604800000;
    localparam int SEC_MS_MAX  = 59999;

    // day numbers
    localparam int MJD_GPS_EPOCH  = 44244;
    localparam int MJD_CAL_OFFSET = 679019;
    // day count since the gps epoch = date sum - N_OFFSET - century correction
    localparam int N_OFFSET       = MJD_CAL_OFFSET + MJD_GPS_EPOCH;

    // mjd to date: b relative to the gps epoch (alpha = 15 at the epoch)
    localparam int B_BASE = MJD_GPS_EPOCH + 2400001 + 1525 + 15 - 15 / 4;
    localparam int C_BASE = (100 * B_BASE - 12210) / 36525;
    localparam int X_BIAS = 100 * B_BASE - 12210 - 36525 * C_BASE;

    // century correction steps, as day offsets from the epoch
    localparam int ALPHA_NUM0 = 4 * (MJD_GPS_EPOCH + 2400001) - 7468865;
    localparam int ALPHA_T17  = (17 * 146097 - ALPHA_NUM0 + 3) / 4;
    localparam int ALPHA_T18  = (18 * 146097 - ALPHA_NUM0 + 3) / 4;

    // year offsets from the 365.25 day count
    localparam int YEAR_OFS_EARLY = 4715;
    localparam int YEAR_OFS_LATE  = 4716;

    // reciprocal multipliers for constant division
    localparam int K_DIV7 = 20;
    localparam longint unsigned M_DIV7 = ((64'd1 << K_DIV7) + 64'd6) / 64'd7;
    localparam int K_HOUR = 49;
    localparam longint unsigned M_HOUR =
        ((64'd1 << K_HOUR) + 64'(MS_PER_HOUR) - 64'd1) / 64'(MS_PER_HOUR);
    localparam int K_MIN = 38;
    localparam longint unsigned M_MIN =
        ((64'd1 << K_MIN) + 64'(MS_PER_MIN) - 64'd1) / 64'(MS_PER_MIN);
    localparam int K_CENT = 40;
    localparam longint unsigned M_CENT = ((64'd1 << K_CENT) + 64'd36524) / 64'd36525;

    // floor(30.6001 * i)
    localparam logic [8:0] DM_TAB [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    typedef struct packed {
        logic        kind;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [13:0] gps_week;
        logic [29:0] sow_ms;
    } cgtc_in_t;

    typedef struct packed {
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [15:0] out_second_ms;
        logic [13:0] out_week;
        logic [29:0] out_sow_ms;
        logic        range_error;
    } cgtc_out_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  out_valid;
    } pipe_ctl_t;

    // days in month, month assumed 1..12
    function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
        logic [4:0] len;
        case (month) inside
            4'd2:
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11:
            begin
                len = 5'd30;
            end
            default:
            begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/cgtc_ifs.sv =====
// request channel
interface cgtc_in_if;
    logic                 valid;
    logic                 ready;
    cgtc_pkg::cgtc_in_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface cgtc_out_if;
    logic                 valid;
    logic                 ready;
    cgtc_pkg::cgtc_out_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/calendar_gps_time_converter_unit.sv =====
// Converts a calendar date and time (year, month, day, hour, minute, milliseconds of
// minute) to GPS week and milliseconds of week when kind is 0, and back when kind is 1,
// through the modified julian day number in exact integer arithmetic; leap seconds are
// not applied. A word that is malformed, falls before 1980-01-06 00:00 or lands after
// year 2200 returns range_error set with every other field zero, and the fields of the
// unused direction are always zero. The unit takes one word per clock while the pipe has
// room; each result passes through eight register stages, paced by the chain of
// reciprocal multiplies (day of week, hour, minute, then the 36525-day century step
// followed by the 365.25-day year step). Words leave in order; a held output stalls only
// the stages that are full, so bubbles close up and new words keep entering.
module calendar_gps_time_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    cgtc_in_if.sink     req,
    cgtc_out_if.source  rsp
);

    typedef struct packed {
        logic        kind;
        logic        err;
        logic [13:0] week;
        logic [29:0] sow_ms;
        logic [4:0]  hour;
    } tail_t;

    cgtc_pkg::pipe_ctl_t ctl;
    cgtc_pkg::cgtc_in_t  in_w;

    // stage 1
    logic        leap;
    logic [4:0]  mdays;
    logic        bad_cal;
    logic [11:0] ya;
    logic [3:0]  tidx;
    logic [1:0]  corr_sub;
    logic [22:0] quarter;
    logic [23:0] sumu;
    logic        n_neg;
    logic [2:0]  dow;
    logic        sow_bad;
    logic [29:0] ms1_full;
    logic        s1_kind_reg, s1_kind_next;
    logic        s1_err_reg, s1_err_next;
    logic [16:0] s1_n_reg, s1_n_next;
    logic [10:0] s1_hm_reg, s1_hm_next;
    logic [15:0] s1_sec_reg;
    logic [16:0] s1_off_reg, s1_off_next;
    logic [26:0] s1_ms1_reg, s1_ms1_next;

    // stage 2
    logic [34:0] q_prod;
    logic [54:0] h_prod;
    logic        s2_kind_reg;
    logic        s2_err_reg;
    logic [16:0] s2_n_reg;
    logic [14:0] s2_q_reg, s2_q_next;
    logic [26:0] s2_ms0_reg, s2_ms0_next;
    logic [16:0] s2_off_reg;
    logic [26:0] s2_ms1_reg;
    logic [4:0]  s2_hour_reg, s2_hour_next;

    // stage 3
    logic [16:0] q7;
    logic [2:0]  rem7;
    logic [26:0] hrem_full;
    logic [1:0]  adj;
    tail_t       s3_tail_reg, s3_tail_next;
    logic [16:0] s3_bd_reg, s3_bd_next;
    logic [21:0] s3_hrem_reg, s3_hrem_next;

    // stage 4
    logic [44:0] m_prod;
    tail_t       s4_tail_reg;
    logic [16:0] s4_bd_reg;
    logic [23:0] s4_x_reg, s4_x_next;
    logic [21:0] s4_hrem_reg;
    logic [5:0]  s4_min_reg, s4_min_next;

    // stage 5
    logic [48:0] c_prod;
    logic [21:0] sec_full;
    tail_t       s5_tail_reg;
    logic [16:0] s5_bd_reg;
    logic [8:0]  s5_cq_reg, s5_cq_next;
    logic [5:0]  s5_min_reg;
    logic [15:0] s5_sec_reg, s5_sec_next;

    // stage 6
    logic [12:0] c_full;
    logic [23:0] d_full;
    logic [21:0] bmd_full;
    tail_t       s6_tail_reg;
    logic [12:0] s6_c_reg;
    logic [8:0]  s6_bmd_reg, s6_bmd_next;
    logic [5:0]  s6_min_reg;
    logic [15:0] s6_sec_reg;

    // stage 7
    tail_t       s7_tail_reg;
    logic [12:0] s7_c_reg;
    logic [8:0]  s7_bmd_reg;
    logic [3:0]  s7_e_reg, s7_e_next;
    logic [5:0]  s7_min_reg;
    logic [15:0] s7_sec_reg;

    // output stage
    logic [8:0]  day_full;
    logic [3:0]  mo;
    logic [12:0] yr;
    logic        yr_bad;
    cgtc_pkg::cgtc_out_t out_reg, out_next;

    cgtc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    assign in_w      = req.data;
    assign req.ready = ctl.load[0];
    assign rsp.valid = ctl.out_valid;
    assign rsp.data  = out_reg;

    // stage 1: field checks, day count since epoch, day of week split
    always_comb
    begin
        leap  = (in_w.year[1:0] == 2'b00) && (in_w.year != 12'd2100) &&
                (in_w.year != 12'd2200);
        mdays = cgtc_pkg::month_days(in_w.month, leap);
        bad_cal = (in_w.year < 12'(cgtc_pkg::YEAR_MIN)) ||
                  (in_w.year > 12'(cgtc_pkg::YEAR_MAX)) ||
                  (in_w.month == 4'd0) || (in_w.month > 4'd12) ||
                  (in_w.day == 5'd0) || (in_w.day > mdays) ||
                  (in_w.hour > 5'd23) || (in_w.minute > 6'd59) ||
                  (in_w.second_ms > 16'(cgtc_pkg::SEC_MS_MAX));

        // january and february count as months 13 and 14 of the year before
        ya   = (in_w.month <= 4'd2) ? in_w.year - 12'd1 : in_w.year;
        tidx = (in_w.month <= 4'd2) ? in_w.month + 4'd13 : in_w.month + 4'd1;
        // gregorian century correction over the span
        corr_sub = (ya >= 12'd2200) ? 2'd2 : ((ya >= 12'd2100) ? 2'd1 : 2'd0);
        quarter  = 23'((23'(ya) * 23'd1461) >> 2);
        sumu     = 24'(quarter) + 24'(cgtc_pkg::DM_TAB[tidx]) + 24'(in_w.day);
        n_neg    = sumu < (24'(cgtc_pkg::N_OFFSET) + 24'(corr_sub));
        s1_n_next  = 17'(sumu - 24'(cgtc_pkg::N_OFFSET) - 24'(corr_sub));
        s1_hm_next = 11'(11'(in_w.hour) * 11'd60 + 11'(in_w.minute));

        // whole days of the week by threshold count
        sow_bad = in_w.sow_ms >= 30'(cgtc_pkg::MS_PER_WEEK);
        dow = 3'd0;
        for (int k = 1; k <= 6; k++)
        begin
            if (in_w.sow_ms >= 30'(k * cgtc_pkg::MS_PER_DAY))
            begin
                dow = dow + 3'd1;
            end
        end
        ms1_full    = in_w.sow_ms - 30'(30'(dow) * 30'(cgtc_pkg::MS_PER_DAY));
        s1_ms1_next = ms1_full[26:0];
        s1_off_next = 17'(17'(in_w.gps_week) * 17'd7 + 17'(dow));

        s1_kind_next = in_w.kind;
        s1_err_next  = (in_w.kind == cgtc_pkg::KIND_GPS2CAL) ? sow_bad : (bad_cal || n_neg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s1_kind_reg <= s1_kind_next;
            s1_err_reg  <= s1_err_next;
            s1_n_reg    <= s1_n_next;
            s1_hm_reg   <= s1_hm_next;
            s1_sec_reg  <= in_w.second_ms;
            s1_off_reg  <= s1_off_next;
            s1_ms1_reg  <= s1_ms1_next;
        end
    end

    // stage 2: weeks from days, time of day in ms, hour of day
    always_comb
    begin
        q_prod       = 35'(s1_n_reg) * 35'(cgtc_pkg::M_DIV7);
        s2_q_next    = q_prod[cgtc_pkg::K_DIV7 +: 15];
        s2_ms0_next  = 27'(27'(s1_hm_reg) * 27'(cgtc_pkg::MS_PER_MIN) + 27'(s1_sec_reg));
        h_prod       = 55'(s1_ms1_reg) * 55'(cgtc_pkg::M_HOUR);
        s2_hour_next = h_prod[cgtc_pkg::K_HOUR +: 5];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_err_reg  <= s1_err_reg;
            s2_n_reg    <= s1_n_reg;
            s2_q_reg    <= s2_q_next;
            s2_ms0_reg  <= s2_ms0_next;
            s2_off_reg  <= s1_off_reg;
            s2_ms1_reg  <= s1_ms1_reg;
            s2_hour_reg <= s2_hour_next;
        end
    end

    // stage 3: ms of week, ms left in the hour, century-corrected day offset
    always_comb
    begin
        q7   = 17'(17'(s2_q_reg) * 17'd7);
        rem7 = 3'(s2_n_reg - q7);
        s3_tail_next.kind   = s2_kind_reg;
        s3_tail_next.err    = s2_err_reg;
        s3_tail_next.week   = s2_q_reg[13:0];
        s3_tail_next.sow_ms = 30'(30'(rem7) * 30'(cgtc_pkg::MS_PER_DAY) + 30'(s2_ms0_reg));
        s3_tail_next.hour   = s2_hour_reg;

        hrem_full    = s2_ms1_reg - 27'(27'(s2_hour_reg) * 27'(cgtc_pkg::MS_PER_HOUR));
        s3_hrem_next = hrem_full[21:0];

        adj = 2'(s2_off_reg >= 17'(cgtc_pkg::ALPHA_T17)) +
              2'(s2_off_reg >= 17'(cgtc_pkg::ALPHA_T18));
        s3_bd_next = s2_off_reg + 17'(adj);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            s3_tail_reg <= s3_tail_next;
            s3_bd_reg   <= s3_bd_next;
            s3_hrem_reg <= s3_hrem_next;
        end
    end

    // stage 4: scaled day count for the century step, minute of hour
    always_comb
    begin
        s4_x_next   = 24'(24'(s3_bd_reg) * 24'd100 + 24'(cgtc_pkg::X_BIAS));
        m_prod      = 45'(s3_hrem_reg) * 45'(cgtc_pkg::M_MIN);
        s4_min_next = m_prod[cgtc_pkg::K_MIN +: 6];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            s4_tail_reg <= s3_tail_reg;
            s4_bd_reg   <= s3_bd_reg;
            s4_x_reg    <= s4_x_next;
            s4_hrem_reg <= s3_hrem_reg;
            s4_min_reg  <= s4_min_next;
        end
    end

    // stage 5: years of 365.25 days past the base, ms of minute
    always_comb
    begin
        c_prod      = 49'(s4_x_reg) * 49'(cgtc_pkg::M_CENT);
        s5_cq_next  = c_prod[cgtc_pkg::K_CENT +: 9];
        sec_full    = s4_hrem_reg - 22'(22'(s4_min_reg) * 22'(cgtc_pkg::MS_PER_MIN));
        s5_sec_next = sec_full[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            s5_tail_reg <= s4_tail_reg;
            s5_bd_reg   <= s4_bd_reg;
            s5_cq_reg   <= s5_cq_next;
            s5_min_reg  <= s4_min_reg;
            s5_sec_reg  <= s5_sec_next;
        end
    end

    // stage 6: days into the shifted year
    always_comb
    begin
        c_full      = 13'(s5_cq_reg) + 13'(cgtc_pkg::C_BASE);
        d_full      = 24'((24'(c_full) * 24'd1461) >> 2);
        bmd_full    = 22'(s5_bd_reg) + 22'(cgtc_pkg::B_BASE) - d_full[21:0];
        s6_bmd_next = bmd_full[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[5])
        begin
            s6_tail_reg <= s5_tail_reg;
            s6_c_reg    <= c_full;
            s6_bmd_reg  <= s6_bmd_next;
            s6_min_reg  <= s5_min_reg;
            s6_sec_reg  <= s5_sec_reg;
        end
    end

    // stage 7: shifted month by 30.6001-day thresholds
    always_comb
    begin
        s7_e_next = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (s6_bmd_reg > cgtc_pkg::DM_TAB[k])
            begin
                s7_e_next = s7_e_next + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[6])
        begin
            s7_tail_reg <= s6_tail_reg;
            s7_c_reg    <= s6_c_reg;
            s7_bmd_reg  <= s6_bmd_reg;
            s7_e_reg    <= s7_e_next;
            s7_min_reg  <= s6_min_reg;
            s7_sec_reg  <= s6_sec_reg;
        end
    end

    // output stage: calendar fields, span check, result word
    always_comb
    begin
        day_full = s7_bmd_reg - cgtc_pkg::DM_TAB[s7_e_reg];
        mo = (s7_e_reg < 4'd14) ? s7_e_reg - 4'd1 : s7_e_reg - 4'd13;
        yr = (mo > 4'd2) ? s7_c_reg - 13'(cgtc_pkg::YEAR_OFS_LATE)
                         : s7_c_reg - 13'(cgtc_pkg::YEAR_OFS_EARLY);
        yr_bad = yr > 13'(cgtc_pkg::YEAR_MAX);

        out_next = '0;
        if (s7_tail_reg.err || ((s7_tail_reg.kind == cgtc_pkg::KIND_GPS2CAL) && yr_bad))
        begin
            out_next.range_error = 1'b1;
        end
        else if (s7_tail_reg.kind == cgtc_pkg::KIND_CAL2GPS)
        begin
            out_next.out_week   = s7_tail_reg.week;
            out_next.out_sow_ms = s7_tail_reg.sow_ms;
        end
        else
        begin
            out_next.out_year      = yr[11:0];
            out_next.out_month     = mo;
            out_next.out_day       = day_full[4:0];
            out_next.out_hour      = s7_tail_reg.hour;
            out_next.out_minute    = s7_min_reg;
            out_next.out_second_ms = s7_sec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[7])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/cgtc_pipe_ctrl.sv =====
module cgtc_pipe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    output cgtc_pkg::pipe_ctl_t ctl
);

    logic [cgtc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [cgtc_pkg::NUM_STAGES-1:0] valid_next;
    logic [cgtc_pkg::NUM_STAGES-1:0] adv;

    // a stage may load when empty or when its word moves on
    always_comb
    begin
        adv[cgtc_pkg::NUM_STAGES-1] = !valid_reg[cgtc_pkg::NUM_STAGES-1] || out_ready;
        for (int i = cgtc_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < cgtc_pkg::NUM_STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load      = adv;
    assign ctl.out_valid = valid_reg[cgtc_pkg::NUM_STAGES-1];

endmodule

// ===== tb/tb_calendar_gps_time_converter_unit.sv =====
`timescale 1ns / 100ps

module tb_calendar_gps_time_converter_unit;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 800;
    localparam int HOLD_CYCLES   = 100;
    localparam int HOLD_AFTER    = 300;
    localparam int IDLE_LIMIT    = 3000;

    logic clk;
    logic rst_n;

    cgtc_in_if  req_ch ();
    cgtc_out_if rsp_ch ();

    // shared pacing state
    int accepted_words = 0;
    int idle_cycles    = 0;
    bit quiet          = 1'b0;
    bit rsp_holding    = 1'b0;
    bit hold_done      = 1'b0;

    // gregorian month length, month assumed 1..12
    function automatic int days_in_month(int year, int month);
        bit leap;
        leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
        case (month)
            2:
            begin
                return leap ? 29 : 28;
            end
            4, 6, 9, 11:
            begin
                return 30;
            end
            default:
            begin
                return 31;
            end
        endcase
    endfunction

    // expected conversions, oldest first
    class conversion_scoreboard;
        cgtc_pkg::cgtc_out_t expected_results[$];
        int                  failures = 0;

        // exact integer calendar / gps conversion through the mjd day number
        function cgtc_pkg::cgtc_out_t convert(cgtc_pkg::cgtc_in_t w);
            cgtc_pkg::cgtc_out_t r;
            longint yr, mo, dy, yy, mm, cent, corr, n, ms;
            longint mjd, sow, z, alpha, b, c, d, e;
            r = '0;
            if (w.kind == cgtc_pkg::KIND_CAL2GPS)
            begin
                yr = w.year;
                mo = w.month;
                dy = w.day;
                if (yr < cgtc_pkg::YEAR_MIN || yr > cgtc_pkg::YEAR_MAX ||
                    mo < 1 || mo > 12 || dy < 1 ||
                    dy > days_in_month(int'(yr), int'(mo)) || w.hour > 23 ||
                    w.minute > 59 || w.second_ms > cgtc_pkg::SEC_MS_MAX)
                begin
                    r.range_error = 1'b1;
                    return r;
                end
                // january and february count as months 13 and 14 of the prior year
                yy   = (mo <= 2) ? yr - 1 : yr;
                mm   = (mo <= 2) ? mo + 12 : mo;
                cent = yy / 100;
                corr = 15 - cent + cent / 4;
                n    = (1461 * yy) / 4 + (306001 * (mm + 1)) / 10000 + dy + corr
                       - cgtc_pkg::MJD_CAL_OFFSET - cgtc_pkg::MJD_GPS_EPOCH;
                if (n < 0)
                begin
                    r.range_error = 1'b1;
                    return r;
                end
                ms = (longint'(w.hour) * 60 + longint'(w.minute)) * cgtc_pkg::MS_PER_MIN +
                     longint'(w.second_ms);
                r.out_week   = 14'(n / 7);
                r.out_sow_ms = 30'((n % 7) * cgtc_pkg::MS_PER_DAY + ms);
            end
            else
            begin
                sow = w.sow_ms;
                if (sow >= cgtc_pkg::MS_PER_WEEK)
                begin
                    r.range_error = 1'b1;
                    return r;
                end
                mjd = cgtc_pkg::MJD_GPS_EPOCH + longint'(w.gps_week) * 7 +
                      sow / cgtc_pkg::MS_PER_DAY;
                ms  = sow % cgtc_pkg::MS_PER_DAY;
                // julian day to gregorian date with century correction
                z     = mjd + 2400001;
                alpha = (4 * z - 7468865) / 146097;
                b     = z + 1525 + alpha - alpha / 4;
                c     = (100 * b - 12210) / 36525;
                d     = (1461 * c) / 4;
                e     = (10000 * (b - d)) / 306001;
                mo    = (e < 14) ? e - 1 : e - 13;
                dy    = b - d - (306001 * e) / 10000;
                yr    = (mo > 2) ? c - 4716 : c - 4715;
                if (yr > cgtc_pkg::YEAR_MAX)
                begin
                    r.range_error = 1'b1;
                    return r;
                end
                r.out_year      = 12'(yr);
                r.out_month     = 4'(mo);
                r.out_day       = 5'(dy);
                r.out_hour      = 5'(ms / cgtc_pkg::MS_PER_HOUR);
                r.out_minute    = 6'((ms / cgtc_pkg::MS_PER_MIN) % 60);
                r.out_second_ms = 16'(ms % cgtc_pkg::MS_PER_MIN);
            end
            return r;
        endfunction

        function void note_request(cgtc_pkg::cgtc_in_t w);
            expected_results.push_back(convert(w));
        endfunction

        function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(cgtc_pkg::cgtc_out_t got);
            cgtc_pkg::cgtc_out_t want;
            bit                  ok;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            ok = field_ok("out_year", want.out_year, got.out_year) &
                 field_ok("out_month", want.out_month, got.out_month) &
                 field_ok("out_day", want.out_day, got.out_day) &
                 field_ok("out_hour", want.out_hour, got.out_hour) &
                 field_ok("out_minute", want.out_minute, got.out_minute) &
                 field_ok("out_second_ms", want.out_second_ms, got.out_second_ms) &
                 field_ok("out_week", want.out_week, got.out_week) &
                 field_ok("out_sow_ms", want.out_sow_ms, got.out_sow_ms) &
                 field_ok("range_error", want.range_error, got.range_error);
            if (!ok)
            begin
                failures++;
            end
        endfunction
    endclass

    conversion_scoreboard sb = new();

    calendar_gps_time_converter_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic cgtc_pkg::cgtc_in_t noise_word();
        logic [95:0]        bits;
        cgtc_pkg::cgtc_in_t w;
        bits = {$urandom(), $urandom(), $urandom()};
        w = bits[$bits(cgtc_pkg::cgtc_in_t)-1:0];
        return w;
    endfunction

    function automatic cgtc_pkg::cgtc_in_t cal_word(int year, int month, int day, int hour,
                                                    int minute, int second_ms);
        cgtc_pkg::cgtc_in_t w;
        w           = noise_word();
        w.kind      = cgtc_pkg::KIND_CAL2GPS;
        w.year      = 12'(year);
        w.month     = 4'(month);
        w.day       = 5'(day);
        w.hour      = 5'(hour);
        w.minute    = 6'(minute);
        w.second_ms = 16'(second_ms);
        return w;
    endfunction

    function automatic cgtc_pkg::cgtc_in_t gps_word(int week, int sow);
        cgtc_pkg::cgtc_in_t w;
        w          = noise_word();
        w.kind     = cgtc_pkg::KIND_GPS2CAL;
        w.gps_week = 14'(week);
        w.sow_ms   = 30'(sow);
        return w;
    endfunction

    function automatic cgtc_pkg::cgtc_in_t valid_cal_word(int year, int month);
        return cal_word(year, month, $urandom_range(1, days_in_month(year, month)),
                        $urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, cgtc_pkg::SEC_MS_MAX));
    endfunction

    // random mix: mostly well-formed requests, some corrupt, some raw noise
    function automatic cgtc_pkg::cgtc_in_t random_word();
        cgtc_pkg::cgtc_in_t w;
        int                 r;
        int                 len;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            w = valid_cal_word($urandom_range(cgtc_pkg::YEAR_MIN, cgtc_pkg::YEAR_MAX),
                               $urandom_range(1, 12));
        end
        else if (r < 75)
        begin
            w = gps_word($urandom_range(0, 11535),
                         $urandom_range(0, cgtc_pkg::MS_PER_WEEK - 1));
        end
        else if (r < 82)
        begin
            // around the end of year 2200
            w = gps_word($urandom_range(11525, 11535),
                         $urandom_range(0, cgtc_pkg::MS_PER_WEEK - 1));
        end
        else if (r < 86)
        begin
            // around the gps epoch
            w = cal_word(cgtc_pkg::YEAR_MIN, 1, $urandom_range(1, 10), $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, cgtc_pkg::SEC_MS_MAX));
        end
        else if (r < 93)
        begin
            // one field out of range
            w = valid_cal_word($urandom_range(cgtc_pkg::YEAR_MIN, cgtc_pkg::YEAR_MAX),
                               $urandom_range(1, 12));
            case ($urandom_range(0, 5))
                0:
                begin
                    w.year = $urandom_range(0, 1)
                             ? 12'($urandom_range(0, cgtc_pkg::YEAR_MIN - 1))
                             : 12'($urandom_range(cgtc_pkg::YEAR_MAX + 1, 4095));
                end
                1:
                begin
                    w.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
                end
                2:
                begin
                    len = days_in_month(int'(w.year), int'(w.month));
                    w.day = (len == 31 || $urandom_range(0, 1)) ? 5'd0
                                                                : 5'($urandom_range(len + 1, 31));
                end
                3:
                begin
                    w.hour = 5'($urandom_range(24, 31));
                end
                4:
                begin
                    w.minute = 6'($urandom_range(60, 63));
                end
                default:
                begin
                    w.second_ms = 16'($urandom_range(cgtc_pkg::SEC_MS_MAX + 1, 65535));
                end
            endcase
        end
        else
        begin
            w = noise_word();
        end
        return w;
    endfunction

    // offer one word and hold it until the block takes it
    task automatic send_word(input cgtc_pkg::cgtc_in_t w);
        int gap;
        gap = (quiet || rsp_holding) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // result side: random stalls, one long hold-off once the pipe is busy
    initial
    begin
        int stall;
        int run;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && accepted_words >= HOLD_AFTER)
            begin
                hold_done    = 1'b1;
                rsp_holding  = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_holding  = 1'b0;
            end
            else if (quiet)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rsp_ch.ready <= 1'b1;
                run = $urandom_range(1, 16);
                repeat (run) @(posedge clk);
            end
        end
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                sb.note_request(req_ch.data);
                accepted_words++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_result(rsp_ch.data);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                    $display("tb_calendar_gps_time_converter_unit NOT OK");
                    $finish;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        cgtc_pkg::cgtc_in_t w;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: epoch edges, span edges, leap days, every bad field
        send_word(cal_word(1980, 1, 6, 0, 0, 0));
        send_word(cal_word(1980, 1, 5, 23, 59, cgtc_pkg::SEC_MS_MAX));
        send_word(cal_word(1980, 1, 1, 0, 0, 0));
        send_word(cal_word(2200, 12, 31, 23, 59, cgtc_pkg::SEC_MS_MAX));
        send_word(cal_word(1979, 12, 31, 12, 0, 0));
        send_word(cal_word(2201, 1, 1, 0, 0, 0));
        send_word(cal_word(2024, 2, 29, 12, 30, 30500));
        send_word(cal_word(2100, 2, 29, 0, 0, 0));
        send_word(cal_word(2000, 2, 29, 6, 7, 8));
        send_word(cal_word(2023, 4, 31, 0, 0, 0));
        send_word(cal_word(2023, 0, 10, 0, 0, 0));
        send_word(cal_word(2023, 13, 10, 0, 0, 0));
        send_word(cal_word(2023, 5, 0, 0, 0, 0));
        send_word(cal_word(2023, 5, 10, 24, 0, 0));
        send_word(cal_word(2023, 5, 10, 0, 60, 0));
        send_word(cal_word(2023, 5, 10, 0, 0, cgtc_pkg::SEC_MS_MAX + 1));
        w = '1;
        w.kind = cgtc_pkg::KIND_CAL2GPS;
        send_word(w);
        send_word(gps_word(0, 0));
        send_word(gps_word(0, cgtc_pkg::MS_PER_WEEK - 1));
        send_word(gps_word(0, cgtc_pkg::MS_PER_WEEK));
        send_word(gps_word(11530, 0));
        send_word(gps_word(11530, cgtc_pkg::MS_PER_WEEK - 1));
        send_word(gps_word(16383, 0));
        w = '1;
        send_word(w);

        // random part, with two stretches of back-to-back traffic
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            quiet = (i >= 150 && i < 250) || (i >= 550 && i < 600);
            send_word(random_word());
        end
        quiet = 1'b0;
        req_ch.valid <= 1'b0;
        @(posedge clk);

        // drain
        while (sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (cgtc_pkg::NUM_STAGES + 4) @(posedge clk);

        if (sb.failures == 0)
        begin
            $display("tb_calendar_gps_time_converter_unit OK");
        end
        else
        begin
            $display("tb_calendar_gps_time_converter_unit NOT OK");
        end
        $finish;
    end

endmodule
